### src/ecgrp_pkg.sv
// Shared types and constants for the ECG R-peak candidate detector.
package ecgrp_pkg;

   // Widths of the fields on the ports
   localparam int unsigned VALUE_BITS = 16;
   localparam int unsigned TIME_BITS = 16;
   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam int unsigned CSR_DATA_BITS = 16;

   // Samples keep only this many low bits (8 to 16)
   localparam int unsigned SAMPLE_BITS = 16;

   // Window depth and the position of its middle
   localparam int unsigned WIN_LEN = 5;
   localparam int unsigned WIN_MID = 2;

   // Reset values
   localparam logic [TIME_BITS-1:0] TIME_RESET = 16'd65534;
   localparam logic [CSR_DATA_BITS-1:0] MIN_GAP_RESET = 16'd55;
   localparam logic [CSR_DATA_BITS-1:0] MIN_INTENSITY_RESET = 16'd100;

   // Register indexes on the configuration port
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_GAP = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_INTENSITY = 2'd1;

   // Operation codes of an input word
   typedef enum logic {
      OP_SAMPLE    = 1'b0,
      OP_LOAD_TIME = 1'b1
   } op_type;

   typedef logic [SAMPLE_BITS-1:0] sample_type;

   // One result word
   typedef struct packed {
      logic                  peak_found;
      logic [VALUE_BITS-1:0] peak_value;
      logic [TIME_BITS-1:0]  time_since_peak;
   } rsp_type;

endpackage

### src/ecgrp_window.sv
// Sample window, held left neighbor, time counter and peak decision.
module ecgrp_window (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  ecgrp_pkg::op_type                     op,
   input  logic [ecgrp_pkg::VALUE_BITS-1:0]      value,
   input  logic [ecgrp_pkg::CSR_DATA_BITS-1:0]   min_gap,
   input  logic [ecgrp_pkg::CSR_DATA_BITS-1:0]   min_intensity,
   output ecgrp_pkg::rsp_type                    result
);

   ecgrp_pkg::sample_type                   window_ff [ecgrp_pkg::WIN_LEN];
   ecgrp_pkg::sample_type                   window_in [ecgrp_pkg::WIN_LEN];
   ecgrp_pkg::sample_type                   left_ff;
   ecgrp_pkg::sample_type                   left_in;
   logic [ecgrp_pkg::TIME_BITS-1:0]         time_ff;
   logic [ecgrp_pkg::TIME_BITS-1:0]         time_in;
   ecgrp_pkg::sample_type                   sample;
   ecgrp_pkg::sample_type                   mid;
   logic                                    keep;
   logic                                    found;

   // Mask the sample, load or advance the counter and decide whether to keep the sample
   always_comb begin
      sample = value[ecgrp_pkg::SAMPLE_BITS-1:0];
      if (op == ecgrp_pkg::OP_LOAD_TIME) begin
         time_in = value;
      end else begin
         time_in = time_ff + 1'b1;
      end
      keep = (op == ecgrp_pkg::OP_SAMPLE) && (time_in > min_gap) &&
             ({{(ecgrp_pkg::CSR_DATA_BITS-ecgrp_pkg::SAMPLE_BITS){1'b0}}, sample}
              >= min_intensity);
   end

   // Shift the window and test the new middle
   always_comb begin
      for (int i = 0; i < ecgrp_pkg::WIN_LEN - 1; i++) begin
         window_in[i] = keep ? window_ff[i+1] : window_ff[i];
      end
      window_in[ecgrp_pkg::WIN_LEN-1] = keep ? sample : window_ff[ecgrp_pkg::WIN_LEN-1];
      mid = window_in[ecgrp_pkg::WIN_MID];
      left_in = left_ff;
      if (keep && (window_in[ecgrp_pkg::WIN_MID-1] != mid)) begin
         left_in = window_in[ecgrp_pkg::WIN_MID-1];
      end
      found = keep &&
              (window_in[ecgrp_pkg::WIN_MID+2] < mid) &&
              (window_in[ecgrp_pkg::WIN_MID+1] < mid) &&
              (window_in[ecgrp_pkg::WIN_MID-1] <= mid) &&
              (window_in[ecgrp_pkg::WIN_MID-2] <= mid) &&
              (left_in < mid);
   end

   // Form the result word for the item being taken
   always_comb begin
      result.peak_found = found;
      result.peak_value = {{(ecgrp_pkg::VALUE_BITS-ecgrp_pkg::SAMPLE_BITS){1'b0}}, mid};
      result.time_since_peak = time_in;
   end

   // Update state on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ecgrp_pkg::WIN_LEN; i++) begin
            window_ff[i] <= '0;
         end
         left_ff <= '0;
         time_ff <= ecgrp_pkg::TIME_RESET;
      end else if (accept) begin
         for (int i = 0; i < ecgrp_pkg::WIN_LEN; i++) begin
            window_ff[i] <= window_in[i];
         end
         left_ff <= left_in;
         time_ff <= time_in;
      end
   end

endmodule

### src/ecgrp_out_buf.sv
// Two-entry result buffer: output register plus skid register.
module ecgrp_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  ecgrp_pkg::rsp_type  in_word,
   output logic                out_valid,
   input  logic                out_stall,
   output ecgrp_pkg::rsp_type  out_word
);

   logic               main_valid_ff;
   logic               main_valid_in;
   logic               skid_valid_ff;
   logic               skid_valid_in;
   ecgrp_pkg::rsp_type main_ff;
   ecgrp_pkg::rsp_type main_in;
   ecgrp_pkg::rsp_type skid_ff;
   ecgrp_pkg::rsp_type skid_in;
   logic               push;
   logic               pop;

   assign in_stall  = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_word  = main_ff;
   assign push      = in_valid && !skid_valid_ff;
   assign pop       = main_valid_ff && !out_stall;

   // Advance the output register from the skid or the input
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in = main_ff;
      skid_in = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            main_in = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_in = in_word;
         end
      end else if (push) begin
         if (!main_valid_ff) begin
            main_valid_in = 1'b1;
            main_in = in_word;
         end else begin
            skid_valid_in = 1'b1;
            skid_in = in_word;
         end
      end
   end

   // Hold control under reset, payload without
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

### src/ecg_r_peak_candidate_detector.sv
// Top level of the ECG R-peak candidate detector.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_op, req_value
//   rsp      out        rsp_valid/rsp_stall  rsp_peak_found, rsp_peak_value,
//                                            rsp_time_since_peak
//   csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// One word per cycle while req_stall is low: the window, counter and peak test
// update in the cycle a word is taken, and its result is registered in the output
// register or, while that is held, the skid register. A two-entry output buffer
// (output plus skid register) sets the stall: req_stall rises only when both
// entries hold untaken results. Reset is synchronous; it clears the window, the
// counter (to 65534) and registers to defaults. csr writes are taken in every cycle.
module ecg_r_peak_candidate_detector (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_op,
   input  logic [ecgrp_pkg::VALUE_BITS-1:0]      req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_peak_found,
   output logic [ecgrp_pkg::VALUE_BITS-1:0]      rsp_peak_value,
   output logic [ecgrp_pkg::TIME_BITS-1:0]       rsp_time_since_peak,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ecgrp_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [ecgrp_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   logic [ecgrp_pkg::CSR_DATA_BITS-1:0] min_gap_ff;
   logic [ecgrp_pkg::CSR_DATA_BITS-1:0] min_intensity_ff;
   logic                                accept;
   ecgrp_pkg::op_type                   op;
   ecgrp_pkg::rsp_type                  step_word;
   ecgrp_pkg::rsp_type                  out_word;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && !req_stall;
   assign op        = ecgrp_pkg::op_type'(req_op);

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_gap_ff <= ecgrp_pkg::MIN_GAP_RESET;
         min_intensity_ff <= ecgrp_pkg::MIN_INTENSITY_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ecgrp_pkg::CSR_MIN_GAP: begin
               min_gap_ff <= csr_wdata;
            end
            ecgrp_pkg::CSR_MIN_INTENSITY: begin
               min_intensity_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // Window state and peak test
   ecgrp_window u_window (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .op            (op),
      .value         (req_value),
      .min_gap       (min_gap_ff),
      .min_intensity (min_intensity_ff),
      .result        (step_word)
   );

   // Result register with skid
   ecgrp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_word   (step_word),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_word  (out_word)
   );

   assign rsp_peak_found      = out_word.peak_found;
   assign rsp_peak_value      = out_word.peak_value;
   assign rsp_time_since_peak = out_word.time_since_peak;

endmodule
